### rtl/rala_pkg.sv
// Package for the Ricart-Agrawala lock node: widths, message codes,
// configuration indexes, controller states and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package rala_pkg;

    localparam int RANK_W     = 5;
    localparam int SEQ_W      = 32;
    localparam int CMD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int RCOUNT_W   = 6;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int S_PAD_W   = S_TDATA_W - RANK_W - SEQ_W;
    localparam int M_PAD_W   = M_TDATA_W - RANK_W - SEQ_W;

    // incoming message codes; the two remaining codes are ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_CLIENT_REQ     = 3'd0,
        CMD_CLIENT_RELEASE = 3'd1,
        CMD_CLIENT_DONE    = 3'd2,
        CMD_PEER_REQ       = 3'd3,
        CMD_PEER_GRANT     = 3'd4,
        CMD_PEER_DONE      = 3'd5
    } cmd_t;

    // outgoing message kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PEER_REQ     = 2'd0,
        KIND_PEER_GRANT   = 2'd1,
        KIND_CLIENT_GRANT = 2'd2,
        KIND_PEER_DONE    = 2'd3
    } kind_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_RANK    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_RANK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_COUNT  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture the accepted input beat
        logic exec;      // evaluate the message and update node state
        logic emit;      // push one result into the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic exec_has_out; // evaluated message produces at least one result
        logic out_free;     // output register can take a result this cycle
        logic emit_last;    // result being emitted ends the run
    } dp_status_t;

endpackage

### rtl/rala_ctrl.sv
// Controller of the lock node: idle / evaluate / emit sequencer.
// Depends on rala_pkg.
`timescale 1ns / 1ps

module rala_ctrl
    import rala_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        cmd.emit    = 1'b0;
        s_tready    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = status.exec_has_out ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/rala_datapath.sv
// Datapath of the lock node: configuration, node state, message evaluation,
// fan-out scan over the peer masks and the output register.
// Depends on rala_pkg.
`timescale 1ns / 1ps

module rala_datapath
    import rala_pkg::*;
#(
    parameter int MAX_SERVERS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctrl_cmd_t             cmd,
    output dp_status_t            status,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [CMD_W-1:0]      s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [KIND_W-1:0]     m_tuser,
    output logic                  m_tlast
);

    localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;

    // configuration
    logic [RANK_W-1:0]   own_rank_reg;
    logic [RANK_W-1:0]   client_rank_reg;
    logic [RCOUNT_W-1:0] rank_count_reg;

    // captured input beat
    logic [CMD_W-1:0]  cmd_in_reg;
    logic [RANK_W-1:0] src_reg;
    logic [SEQ_W-1:0]  seq_in_reg;

    // node state
    logic [MAX_SERVERS-1:0] departed_reg, departed_next;
    logic [MAX_SERVERS-1:0] deferred_reg, deferred_next;
    logic                   want_reg, want_next;
    logic                   holding_reg, holding_next;
    logic                   finished_reg, finished_next;
    logic [SEQ_W-1:0]       next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]       req_seq_reg, req_seq_next;
    logic [COUNT_W-1:0]     grants_reg, grants_next;
    logic [COUNT_W-1:0]     asked_reg, asked_next;

    // pending run of results
    logic [MAX_SERVERS-1:0] emit_mask_reg, emit_mask_next;
    logic                   emit_single_reg, emit_single_next;
    kind_t                  emit_kind_reg, emit_kind_next;
    logic [SEQ_W-1:0]       emit_seq_reg, emit_seq_next;
    logic [RANK_W-1:0]      emit_dest_reg, emit_dest_next;

    // output register
    logic              m_tvalid_reg;
    kind_t             out_kind_reg;
    logic [RANK_W-1:0] out_dest_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic              out_last_reg;

    logic [MAX_SERVERS-1:0] active;
    logic [MAX_SERVERS-1:0] peer_bit;
    logic                   peer_ok;
    logic                   grant;
    logic [COUNT_W-1:0]     grants_inc;
    logic [MAX_SERVERS-1:0] lowest;
    logic [MAX_SERVERS-1:0] mask_rest;
    logic [IDX_W-1:0]       low_idx;
    logic [IDX_W:0]         low_rank;
    logic [RANK_W-1:0]      emit_dest;
    logic                   emit_last;

    // configuration writes; the port never stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_rank_reg    <= '0;
            client_rank_reg <= RANK_W'(1);
            rank_count_reg  <= RCOUNT_W'(32);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OWN_RANK:    own_rank_reg    <= cfg_data[RANK_W-1:0];
                CFG_CLIENT_RANK: client_rank_reg <= cfg_data[RANK_W-1:0];
                CFG_RANK_COUNT:  rank_count_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_in_reg <= s_tuser;
            src_reg    <= s_tdata[RANK_W-1:0];
            seq_in_reg <= s_tdata[RANK_W+SEQ_W-1:RANK_W];
        end
    end

    // active peers: even ranks below rank_count, not self, not departed
    always_comb
    begin
        for (int i = 0; i < MAX_SERVERS; i++)
        begin
            active[i] = (7'(2 * i) < {1'b0, rank_count_reg})
                     && (7'(2 * i) != {2'b00, own_rank_reg})
                     && !departed_reg[i];
        end
    end

    // sender checks
    assign peer_ok = !src_reg[0] && ({28'd0, src_reg[RANK_W-1:1]} < 32'(MAX_SERVERS));

    always_comb
    begin
        for (int j = 0; j < MAX_SERVERS; j++)
        begin
            peer_bit[j] = peer_ok && (6'(j) == {2'b00, src_reg[RANK_W-1:1]});
        end
    end

    // conflict rule: lower sequence wins, ties to the lower rank
    always_comb
    begin
        if (!want_reg)
        begin
            grant = 1'b1;
        end
        else if (holding_reg)
        begin
            grant = 1'b0;
        end
        else
        begin
            grant = (seq_in_reg < req_seq_reg)
                 || ((seq_in_reg == req_seq_reg) && (src_reg < own_rank_reg));
        end
    end

    assign grants_inc = grants_reg + COUNT_W'(1);

    // lowest pending peer of the fan-out
    assign lowest    = emit_mask_reg & (~emit_mask_reg + MAX_SERVERS'(1));
    assign mask_rest = emit_mask_reg & ~lowest;

    always_comb
    begin
        low_idx = '0;
        for (int k = 0; k < MAX_SERVERS; k++)
        begin
            if (lowest[k])
            begin
                low_idx = low_idx | IDX_W'(k);
            end
        end
    end

    assign low_rank  = {low_idx, 1'b0};
    assign emit_dest = emit_single_reg ? emit_dest_reg : RANK_W'(low_rank);
    assign emit_last = emit_single_reg || (mask_rest == '0);

    // message evaluation and fan-out stepping
    always_comb
    begin
        departed_next    = departed_reg;
        deferred_next    = deferred_reg;
        want_next        = want_reg;
        holding_next     = holding_reg;
        finished_next    = finished_reg;
        next_seq_next    = next_seq_reg;
        req_seq_next     = req_seq_reg;
        grants_next      = grants_reg;
        asked_next       = asked_reg;
        emit_mask_next   = emit_mask_reg;
        emit_single_next = emit_single_reg;
        emit_kind_next   = emit_kind_reg;
        emit_seq_next    = emit_seq_reg;
        emit_dest_next   = emit_dest_reg;
        if (cmd.exec)
        begin
            emit_mask_next   = '0;
            emit_single_next = 1'b0;
            emit_kind_next   = KIND_PEER_GRANT;
            emit_seq_next    = '0;
            emit_dest_next   = src_reg;
            if (!finished_reg)
            begin
                case (cmd_in_reg)
                    CMD_CLIENT_REQ:
                    begin
                        if (!want_reg)
                        begin
                            want_next     = 1'b1;
                            next_seq_next = next_seq_reg + SEQ_W'(1);
                            if (active != '0)
                            begin
                                // asked_reg is counted as the requests go out
                                grants_next    = '0;
                                asked_next     = '0;
                                req_seq_next   = next_seq_reg;
                                emit_mask_next = active;
                                emit_kind_next = KIND_PEER_REQ;
                                emit_seq_next  = next_seq_reg;
                            end
                            else
                            begin
                                holding_next     = 1'b1;
                                emit_single_next = 1'b1;
                                emit_kind_next   = KIND_CLIENT_GRANT;
                                emit_dest_next   = client_rank_reg;
                            end
                        end
                    end
                    CMD_CLIENT_RELEASE:
                    begin
                        if (holding_reg)
                        begin
                            want_next      = 1'b0;
                            holding_next   = 1'b0;
                            emit_mask_next = deferred_reg;
                            emit_kind_next = KIND_PEER_GRANT;
                            deferred_next  = '0;
                        end
                    end
                    CMD_CLIENT_DONE:
                    begin
                        emit_mask_next = active;
                        emit_kind_next = KIND_PEER_DONE;
                        finished_next  = 1'b1;
                    end
                    CMD_PEER_REQ:
                    begin
                        if (peer_ok)
                        begin
                            if (seq_in_reg >= next_seq_reg)
                            begin
                                next_seq_next = seq_in_reg + SEQ_W'(1);
                            end
                            if (grant)
                            begin
                                emit_single_next = 1'b1;
                                emit_kind_next   = KIND_PEER_GRANT;
                            end
                            else
                            begin
                                deferred_next = deferred_reg | peer_bit;
                            end
                        end
                    end
                    CMD_PEER_GRANT:
                    begin
                        if (peer_ok && want_reg && !holding_reg)
                        begin
                            grants_next = grants_inc;
                            if (grants_inc == asked_reg)
                            begin
                                holding_next     = 1'b1;
                                emit_single_next = 1'b1;
                                emit_kind_next   = KIND_CLIENT_GRANT;
                                emit_dest_next   = client_rank_reg;
                            end
                        end
                    end
                    CMD_PEER_DONE:
                    begin
                        departed_next = departed_reg | peer_bit;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (cmd.emit)
        begin
            emit_single_next = 1'b0;
            if (!emit_single_reg)
            begin
                emit_mask_next = mask_rest;
                if (emit_kind_reg == KIND_PEER_REQ)
                begin
                    asked_next = asked_reg + COUNT_W'(1);
                end
            end
        end
    end

    // node state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            departed_reg    <= '0;
            deferred_reg    <= '0;
            want_reg        <= 1'b0;
            holding_reg     <= 1'b0;
            finished_reg    <= 1'b0;
            next_seq_reg    <= SEQ_W'(1);
            req_seq_reg     <= '0;
            grants_reg      <= '0;
            asked_reg       <= '0;
            emit_mask_reg   <= '0;
            emit_single_reg <= 1'b0;
        end
        else
        begin
            departed_reg    <= departed_next;
            deferred_reg    <= deferred_next;
            want_reg        <= want_next;
            holding_reg     <= holding_next;
            finished_reg    <= finished_next;
            next_seq_reg    <= next_seq_next;
            req_seq_reg     <= req_seq_next;
            grants_reg      <= grants_next;
            asked_reg       <= asked_next;
            emit_mask_reg   <= emit_mask_next;
            emit_single_reg <= emit_single_next;
        end
    end

    // run payload, meaningful only while a run is pending
    always_ff @(posedge clk)
    begin
        emit_kind_reg <= emit_kind_next;
        emit_seq_reg  <= emit_seq_next;
        emit_dest_reg <= emit_dest_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_kind_reg <= emit_kind_reg;
            out_dest_reg <= emit_dest;
            out_seq_reg  <= emit_seq_reg;
            out_last_reg <= emit_last;
        end
    end

    assign status.exec_has_out = emit_single_next || (emit_mask_next != '0);
    assign status.out_free     = !m_tvalid_reg || m_tready;
    assign status.emit_last    = emit_last;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_seq_reg, out_dest_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

### rtl/ricart_agrawala_lock_node_unit.sv
// Top level of one Ricart-Agrawala lock node: controller plus datapath.
// Depends on rala_pkg, rala_ctrl, rala_datapath.
`timescale 1ns / 1ps

// One server node of a distributed lock. Each input beat is one message from
// the local client or a peer server (kind in s_tuser); the node answers with
// a run of zero to MAX_SERVERS result beats, the final one marked by m_tlast.
// An item is accepted in ST_IDLE and evaluated in ST_EXEC; ST_EMIT then hands
// its results to the output register one message per cycle while that register
// is free, so m_tready back-pressure stalls the run. No new item is taken until
// the run ends; the next item is taken while the final result still sits in
// the output register. Peer requests, releases and done notices go out in
// ascending rank order.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while the node is idle. No clearing pass after reset.

module ricart_agrawala_lock_node_unit
    import rala_pkg::*;
#(
    parameter int MAX_SERVERS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input messages
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // source_rank[4:0], seq_in[36:5], zero pad
    input  logic [CMD_W-1:0]      s_tuser,   // cmd[2:0]
    // result messages
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // dest_rank[4:0], seq_out[36:5], zero pad
    output logic [KIND_W-1:0]     m_tuser,   // out_kind[1:0]
    output logic                  m_tlast,   // last
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rala_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rala_datapath #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // a result is only pushed when the output register can take it
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result pushed into a full output register");

    // no new input is taken while a run is still being emitted
    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !s_tready)
        else $error("input ready while emitting results");

    // a message that causes nothing returns the node to idle at once
    a_silent_item_returns: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !status.exec_has_out) |=> s_tready)
        else $error("node not idle after a message without results");

endmodule

### test/tb.sv
// Self-checking bench for ricart_agrawala_lock_node_unit: streams lock messages
// in, predicts every result beat and compares it field by field.
// Depends on rala_pkg and the RTL of the lock node.
`timescale 1ns / 1ps

module tb;
    import rala_pkg::*;

    localparam int NODES        = 16;
    localparam int IDLE_PCT     = 19;
    localparam int RANDOM_ITEMS = 130;
    localparam int PHASES       = 7;
    localparam int SETTLE       = 2 + NODES + 8;

    // one input message
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [RANK_W-1:0] src;
        logic [SEQ_W-1:0]  seq;
    } lock_req_t;

    // one outgoing message
    typedef struct packed {
        kind_t             kind;
        logic [RANK_W-1:0] dest;
        logic [SEQ_W-1:0]  seq;
        logic              last;
    } lock_msg_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // source_rank[4:0], seq_in[36:5], zero pad
    logic [CMD_W-1:0]      s_tuser = '0;   // cmd[2:0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // dest_rank[4:0], seq_out[36:5], zero pad
    logic [KIND_W-1:0]     m_tuser;        // out_kind[1:0]
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    ricart_agrawala_lock_node_unit #(.MAX_SERVERS(NODES)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // node configuration and state as the lock protocol evolves it
    logic [RANK_W-1:0]   own_rank_q = 5'd0;
    logic [RANK_W-1:0]   client_rank_q = 5'd1;
    logic [RCOUNT_W-1:0] rank_count_q = 6'd32;
    logic [NODES-1:0]    departed_q = '0;
    logic [NODES-1:0]    deferred_q = '0;
    logic                wanting = 1'b0;
    logic                holding = 1'b0;
    logic                done_flag = 1'b0;
    logic [SEQ_W-1:0]    seq_next = 32'd1;
    logic [SEQ_W-1:0]    seq_req = '0;
    logic [COUNT_W-1:0]  grants_got = '0;
    logic [COUNT_W-1:0]  peers_needed = '0;

    lock_req_t pending_msgs[$];
    lock_msg_t expected_msgs[$];
    lock_req_t on_bus;
    int        queued = 0;
    int        accepted = 0;
    int        made = 0;
    int        errors = 0;
    int        results_seen = 0;
    int        cfg_writes = 0;
    int        kind_seen[4] = '{0, 0, 0, 0};
    bit        steady = 1'b0;

    function automatic lock_msg_t outgoing(input kind_t k, input logic [RANK_W-1:0] d,
                                           input logic [SEQ_W-1:0] s, input logic l);
        lock_msg_t r;
        r.kind = k;
        r.dest = d;
        r.seq  = s;
        r.last = l;
        return r;
    endfunction

    // even ranks below rank_count, not ours, not departed
    function automatic logic [NODES-1:0] live_peers();
        logic [NODES-1:0] m;
        m = '0;
        for (int i = 0; i < NODES; i++)
            if (2 * i < int'(rank_count_q) && 2 * i != int'(own_rank_q) && !departed_q[i])
                m[i] = 1'b1;
        return m;
    endfunction

    // one message per set bit, ascending rank, last on the highest
    task automatic fan_out(input logic [NODES-1:0] mask, input kind_t k,
                           input logic [SEQ_W-1:0] s);
        int left;
        left = $countones(mask);
        for (int i = 0; i < NODES; i++)
            if (mask[i])
            begin
                left--;
                expected_msgs.push_back(outgoing(k, RANK_W'(2 * i), s, left == 0));
            end
    endtask

    // advance the lock state by one message and queue the results it causes
    task automatic apply_message(input lock_req_t m);
        logic [NODES-1:0] live;
        logic [NODES-1:0] bit_mask;
        logic             peer_ok;
        logic             grant;
        peer_ok = !m.src[0] && int'(m.src[RANK_W-1:1]) < NODES;
        bit_mask = '0;
        bit_mask[m.src[RANK_W-1:1]] = peer_ok;
        if (done_flag)
            return;
        case (m.cmd)
            CMD_CLIENT_REQ:
                if (!wanting)
                begin
                    wanting = 1'b1;
                    live = live_peers();
                    if (live != '0)
                    begin
                        grants_got = '0;
                        seq_req = seq_next;
                        peers_needed = COUNT_W'($countones(live));
                        fan_out(live, KIND_PEER_REQ, seq_req);
                    end
                    else
                    begin
                        holding = 1'b1;
                        expected_msgs.push_back(outgoing(KIND_CLIENT_GRANT, client_rank_q,
                                                         '0, 1'b1));
                    end
                    seq_next = seq_next + SEQ_W'(1);
                end
            CMD_CLIENT_RELEASE:
                if (holding)
                begin
                    wanting = 1'b0;
                    holding = 1'b0;
                    fan_out(deferred_q, KIND_PEER_GRANT, '0);
                    deferred_q = '0;
                end
            CMD_CLIENT_DONE:
            begin
                fan_out(live_peers(), KIND_PEER_DONE, '0);
                done_flag = 1'b1;
            end
            CMD_PEER_REQ:
                if (peer_ok)
                begin
                    if (m.seq >= seq_next)
                        seq_next = m.seq + SEQ_W'(1);
                    if (!wanting)
                        grant = 1'b1;
                    else if (holding)
                        grant = 1'b0;
                    else
                        grant = (m.seq < seq_req) || (m.seq == seq_req && m.src < own_rank_q);
                    if (grant)
                        expected_msgs.push_back(outgoing(KIND_PEER_GRANT, m.src, '0, 1'b1));
                    else
                        deferred_q = deferred_q | bit_mask;
                end
            CMD_PEER_GRANT:
                if (peer_ok && wanting && !holding)
                begin
                    grants_got = grants_got + COUNT_W'(1);
                    if (grants_got == peers_needed)
                    begin
                        holding = 1'b1;
                        expected_msgs.push_back(outgoing(KIND_CLIENT_GRANT, client_rank_q,
                                                         '0, 1'b1));
                    end
                end
            CMD_PEER_DONE:
                if (peer_ok)
                    departed_q = departed_q | bit_mask;
            default: ;
        endcase
    endtask

    // input driver: predicts on every accepted beat, then loads the next message
    always @(posedge clk or negedge rst_n)
    begin : driver
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_message(on_bus);
                accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_msgs.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    on_bus = pending_msgs.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= on_bus.cmd;
                    s_tdata  <= {{S_PAD_W{1'b0}}, on_bus.seq, on_bus.src};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin : monitor
        lock_msg_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                kind_seen[m_tuser]++;
                if (expected_msgs.size() == 0)
                begin
                    $error("result beat with no message pending: kind %0d dest %0d",
                           m_tuser, m_tdata[RANK_W-1:0]);
                    errors++;
                end
                else
                begin
                    want = expected_msgs.pop_front();
                    if (m_tuser != want.kind)
                    begin
                        $error("out_kind: expected %0d, actual %0d", want.kind, m_tuser);
                        errors++;
                    end
                    if (m_tdata[RANK_W-1:0] != want.dest)
                    begin
                        $error("dest_rank: expected %0d, actual %0d", want.dest,
                               m_tdata[RANK_W-1:0]);
                        errors++;
                    end
                    if (m_tdata[RANK_W+SEQ_W-1:RANK_W] != want.seq)
                    begin
                        $error("seq_out: expected %0h, actual %0h", want.seq,
                               m_tdata[RANK_W+SEQ_W-1:RANK_W]);
                        errors++;
                    end
                    if (m_tlast != want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, m_tlast);
                        errors++;
                    end
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [RANK_W-1:0] src,
                        input logic [SEQ_W-1:0] seq);
        lock_req_t m;
        m.cmd = cmd;
        m.src = src;
        m.seq = seq;
        pending_msgs.push_back(m);
        queued++;
    endtask

    function automatic logic [RANK_W-1:0] even_rank();
        return RANK_W'(2 * $urandom_range(0, NODES - 1));
    endfunction

    // sequence numbers around the one in use, plus the wrap points
    function automatic logic [SEQ_W-1:0] seq_near(input logic [SEQ_W-1:0] rs);
        case ($urandom_range(0, 5))
            0: return rs;
            1: return rs - 1;
            2: return rs + 1;
            3: return '0;
            4: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_accepted();
        do @(negedge clk); while (accepted != queued);
    endtask

    // everything taken and answered, then enough cycles for a silent item
    task automatic drain();
        do @(negedge clk); while (accepted != queued || expected_msgs.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_OWN_RANK:    own_rank_q = value[RANK_W-1:0];
            CFG_CLIENT_RANK: client_rank_q = value[RANK_W-1:0];
            CFG_RANK_COUNT:  rank_count_q = value[RCOUNT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // messages the node must drop while a request is outstanding
    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send(CMD_W'($urandom_range(6, 7)), RANK_W'($urandom), $urandom);
            1: send(CMD_W'($urandom_range(3, 5)), RANK_W'(2 * $urandom_range(0, 15) + 1),
                    $urandom);
            2: send(CMD_CLIENT_REQ, RANK_W'($urandom), $urandom);
            default: send(CMD_CLIENT_RELEASE, RANK_W'($urandom), $urandom);
        endcase
    endtask

    // one full lock cycle: request, grants with competing requests, release
    task automatic run_session(input int ph);
        int               live_n;
        logic [SEQ_W-1:0] rs;
        wait_accepted();
        // bring the node back to idle if an earlier cycle was left open
        while (wanting)
        begin
            if (holding)
                send(CMD_CLIENT_RELEASE, RANK_W'($urandom), $urandom);
            else
                send(CMD_PEER_GRANT, even_rank(), $urandom);
            wait_accepted();
        end
        live_n = $countones(live_peers());
        rs = seq_next;
        send(CMD_CLIENT_REQ, RANK_W'($urandom), $urandom);
        made++;
        for (int i = 0; i < live_n; i++)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                send(CMD_PEER_REQ, even_rank(), seq_near(rs));
                made++;
            end
            if ($urandom_range(0, 7) == 0)
                send_noise();
            send(CMD_PEER_GRANT, even_rank(), $urandom);
            made++;
        end
        // requests that arrive while the lock is held get deferred
        repeat ($urandom_range(0, 3))
        begin
            send(CMD_PEER_REQ, even_rank(), seq_near(rs));
            made++;
        end
        if (ph >= 4 && $urandom_range(0, 9) == 0)
        begin
            send(CMD_PEER_DONE, even_rank(), $urandom);
            made++;
        end
        send(CMD_CLIENT_RELEASE, RANK_W'($urandom), $urandom);
        made++;
    endtask

    initial
    begin : stimulus
        int unsigned own_tbl[PHASES]    = '{7, 0, 30, 0, 12, 2, 13};
        int unsigned client_tbl[PHASES] = '{17, 1, 31, 0, 5, 31, 9};
        int unsigned count_tbl[PHASES]  = '{32, 32, 31, 1, 20, 3, 17};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part: three peers 0, 2, 6 around own rank 4
        write_reg(CFG_OWN_RANK, 4);
        write_reg(CFG_CLIENT_RANK, 31);
        write_reg(CFG_RANK_COUNT, 7);
        send(3'd6, 5'd0, 32'h0);                       // unknown kinds
        send(3'd7, 5'd31, 32'hFFFF_FFFF);
        send(CMD_PEER_REQ, 5'd31, 32'd5);              // odd peer sender
        send(CMD_PEER_GRANT, 5'd2, 32'd0);             // grant out of turn
        send(CMD_CLIENT_RELEASE, 5'd0, 32'd0);         // release without lock
        send(CMD_PEER_DONE, 5'd5, 32'd0);              // odd peer sender
        send(CMD_PEER_REQ, 5'd0, 32'hFFFF_FFFF);       // granted, counter wraps to zero
        send(CMD_CLIENT_REQ, 5'd31, 32'h0);            // requests carry sequence zero
        send(CMD_CLIENT_REQ, 5'd3, 32'h0);             // already wanting
        send(CMD_PEER_REQ, 5'd2, 32'd0);               // tie, lower rank wins
        send(CMD_PEER_REQ, 5'd6, 32'd0);               // tie, higher rank deferred
        send(CMD_PEER_REQ, 5'd0, 32'd7);               // later number deferred
        send(CMD_PEER_GRANT, 5'd0, 32'd0);
        send(CMD_PEER_GRANT, 5'd2, 32'd0);
        send(CMD_PEER_GRANT, 5'd6, 32'd0);             // client granted
        send(CMD_PEER_GRANT, 5'd6, 32'd0);             // already holding
        send(CMD_PEER_REQ, 5'd2, 32'd0);               // deferred while holding
        send(CMD_PEER_REQ, 5'd6, 32'd1);               // deferred a second time
        send(CMD_CLIENT_RELEASE, 5'd31, 32'd0);        // grants 0, 2, 6 once each
        send(CMD_CLIENT_REQ, 5'd0, 32'd0);
        send(CMD_PEER_REQ, 5'd0, 32'd0);               // earlier number wins
        send(CMD_PEER_GRANT, 5'd0, 32'd0);
        send(CMD_PEER_GRANT, 5'd2, 32'd0);
        send(CMD_PEER_GRANT, 5'd6, 32'd0);
        send(CMD_CLIENT_RELEASE, 5'd1, 32'd0);         // nothing deferred

        // random lock cycles under several node settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_reg(CFG_OWN_RANK, own_tbl[ph]);
            write_reg(CFG_CLIENT_RANK, client_tbl[ph]);
            write_reg(CFG_RANK_COUNT, count_tbl[ph]);
            @(negedge clk);
            steady = (ph == 4);
            if (ph == 3)
            begin
                send(CMD_PEER_DONE, 5'd6, $urandom);
                made++;
            end
            while (made < RANDOM_ITEMS * (ph + 1) / PHASES)
                run_session(ph);
        end

        // done notice to the remaining peers, then nothing is answered
        wait_accepted();
        send(CMD_CLIENT_DONE, RANK_W'($urandom), $urandom);
        send(CMD_CLIENT_REQ, 5'd1, 32'd0);
        send(CMD_PEER_REQ, 5'd0, 32'd0);
        send(CMD_PEER_DONE, 5'd2, 32'd0);
        drain();

        $display("Run: %0d messages over %0d register writes, %0d result beats checked",
                 accepted, cfg_writes, results_seen);
        $display("Result kinds: %0d requests, %0d peer grants, %0d client grants, %0d done",
                 kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // hang guard
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

### files.f
rtl/rala_pkg.sv
rtl/rala_ctrl.sv
rtl/rala_datapath.sv
rtl/ricart_agrawala_lock_node_unit.sv
test/tb.sv
